FILE: src/nprs_pkg.sv
// Package for the NAND page read sequencer: item, state and burst types,
// operation and action codes, and the fixed bus constants.
// No dependencies; every other file of the block imports it.
package nprs_pkg;

  // Field widths of the request and result transfers.
  localparam int unsigned START_ADDR_W = 28;
  localparam int unsigned LENGTH_W     = 24;
  localparam int unsigned INDEX_W      = 24;

  // A single request causes at most this many results.
  localparam int unsigned MAX_RESULTS = 10;
  localparam int unsigned COUNT_W     = $clog2(MAX_RESULTS + 1);

  // Flash command codes and the good-block marker.
  localparam logic [7:0] CMD_READ    = 8'h00;
  localparam logic [7:0] CMD_CONFIRM = 8'h30;
  localparam logic [7:0] GOOD_MARK   = 8'hFF;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_READY = 2'd1,
    ACT_DATA  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    OP_SELECT   = 3'd0,
    OP_DESELECT = 3'd1,
    OP_COMMAND  = 3'd2,
    OP_ADDRESS  = 3'd3,
    OP_STROBE   = 3'd4,
    OP_DELIVER  = 3'd5,
    OP_DONE     = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_BYTE = 2'd2
  } phase_e;

  // One request as held in the input register.
  typedef struct packed {
    logic [1:0]              action;
    logic [START_ADDR_W-1:0] start_address;
    logic [LENGTH_W-1:0]     read_length;
    logic                    ready_flag;
    logic [7:0]              flash_byte;
  } item_t;

  // Sequencer state apart from the address, whose width is a parameter.
  typedef struct packed {
    phase_e              phase;
    logic [LENGTH_W-1:0] delivered;
    logic [LENGTH_W-1:0] wanted;
    logic                checking;
  } state_t;

  // One bus operation of a burst.
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } res_entry_t;

  // All results caused by one request; only the first entry can be a delivery.
  typedef struct packed {
    logic [COUNT_W-1:0]                count;
    res_entry_t [MAX_RESULTS-1:0]      entries;
    logic [INDEX_W-1:0]                index;
  } burst_t;

  // One result as held in the output register.
  typedef struct packed {
    op_e                operation;
    logic [7:0]         bus_byte;
    logic [INDEX_W-1:0] buffer_index;
    logic               last;
  } res_t;

  function automatic res_entry_t make_entry(op_e op, logic [7:0] data);
    res_entry_t e;
    e.op   = op;
    e.data = data;
    return e;
  endfunction

endpackage

FILE: src/nprs_if.sv
// Channel interfaces of the NAND page read sequencer: request and result.
// Depends on nprs_pkg for the field widths.
interface nprs_req_if;
  import nprs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [START_ADDR_W-1:0] start_address;
  logic [LENGTH_W-1:0]     read_length;
  logic                    ready_flag;
  logic [7:0]              flash_byte;

  modport source (
    output valid, action, start_address, read_length, ready_flag, flash_byte,
    input  ready
  );
  modport sink (
    input  valid, action, start_address, read_length, ready_flag, flash_byte,
    output ready
  );
endinterface

interface nprs_res_if;
  import nprs_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [7:0]         bus_byte;
  logic [INDEX_W-1:0] buffer_index;
  logic               last;

  modport source (
    output valid, operation, bus_byte, buffer_index, last,
    input  ready
  );
  modport sink (
    input  valid, operation, bus_byte, buffer_index, last,
    output ready
  );
endinterface

FILE: src/nprs_step.sv
// Next-state and burst logic of the NAND page read sequencer: one request
// in, the new state and the list of bus operations out. Depends on nprs_pkg.
module nprs_step #(
  parameter int unsigned PAGE_BYTES   = 2048,
  parameter int unsigned BLOCK_BYTES  = 131072,
  parameter int unsigned ADDRESS_BITS = 28
) (
  input  nprs_pkg::item_t          item_i,
  input  nprs_pkg::state_t         state_i,
  input  logic [ADDRESS_BITS-1:0]  addr_i,
  output nprs_pkg::state_t         state_o,
  output logic [ADDRESS_BITS-1:0]  addr_o,
  output nprs_pkg::burst_t         burst_o
);
  import nprs_pkg::*;

  localparam int unsigned PageBits  = $clog2(PAGE_BYTES);
  localparam int unsigned BlockBits = $clog2(BLOCK_BYTES);

  logic [ADDRESS_BITS-1:0] start_addr;
  logic [ADDRESS_BITS-1:0] addr_inc;
  logic [ADDRESS_BITS-1:0] addr_blk;
  logic [ADDRESS_BITS-1:0] open_addr;
  logic                    open_check;
  logic [31:0]             open_ext;
  logic [23:0]             row;
  logic [15:0]             col;
  logic                    spare_open;
  res_entry_t [7:0]        open_seq;
  logic [LENGTH_W-1:0]     delivered_inc;
  action_e                 action;

  // Address arithmetic wraps at the top of the address range.
  assign start_addr    = ADDRESS_BITS'(32'(item_i.start_address));
  assign addr_inc      = ADDRESS_BITS'(addr_i + ADDRESS_BITS'(1));
  assign addr_blk      = ADDRESS_BITS'(addr_i + ADDRESS_BITS'(BLOCK_BYTES));
  assign delivered_inc = LENGTH_W'(state_i.delivered + LENGTH_W'(1));
  assign action        = action_e'(item_i.action);

  // Address of the page that this request would open.
  always_comb begin
    open_addr  = start_addr;
    open_check = 1'b1;
    if (action == ACT_DATA) begin
      if (state_i.checking) begin
        if (item_i.flash_byte == GOOD_MARK) begin
          open_addr  = addr_i;
          open_check = 1'b0;
        end else begin
          open_addr = addr_blk;
        end
      end else begin
        open_addr = addr_inc;
      end
    end
  end

  // Page open sequence; a block start first reads the spare marker byte.
  always_comb begin
    open_ext    = 32'(open_addr);
    row         = 24'(open_ext >> PageBits);
    spare_open  = open_check && (open_ext[BlockBits-1:0] == '0);
    col         = spare_open ? 16'(PAGE_BYTES) : 16'(open_ext[PageBits-1:0]);
    open_seq[0] = make_entry(OP_SELECT, 8'h00);
    open_seq[1] = make_entry(OP_COMMAND, CMD_READ);
    open_seq[2] = make_entry(OP_ADDRESS, col[7:0]);
    open_seq[3] = make_entry(OP_ADDRESS, col[15:8]);
    open_seq[4] = make_entry(OP_ADDRESS, row[7:0]);
    open_seq[5] = make_entry(OP_ADDRESS, row[15:8]);
    open_seq[6] = make_entry(OP_ADDRESS, row[23:16]);
    open_seq[7] = make_entry(OP_COMMAND, CMD_CONFIRM);
  end

  // Request decode: new state and the burst of results.
  always_comb begin
    state_o = state_i;
    addr_o  = addr_i;
    burst_o = '0;
    case (action)
      ACT_START: begin
        if (state_i.phase == PH_IDLE) begin
          addr_o            = start_addr;
          state_o.wanted    = item_i.read_length;
          state_o.delivered = '0;
          state_o.checking  = 1'b0;
          if (item_i.read_length == '0) begin
            burst_o.count      = COUNT_W'(1);
            burst_o.entries[0] = make_entry(OP_DONE, 8'h00);
          end else begin
            burst_o.count        = COUNT_W'(8);
            burst_o.entries[7:0] = open_seq;
            state_o.phase        = PH_WAIT;
            state_o.checking     = spare_open;
          end
        end
      end
      ACT_READY: begin
        if (state_i.phase == PH_WAIT && item_i.ready_flag) begin
          burst_o.count      = COUNT_W'(1);
          burst_o.entries[0] = make_entry(OP_STROBE, 8'h00);
          state_o.phase      = PH_BYTE;
        end
      end
      ACT_DATA: begin
        if (state_i.phase == PH_BYTE) begin
          if (state_i.checking) begin
            // Spare marker read: reopen this block or skip to the next one.
            burst_o.count      = COUNT_W'(9);
            burst_o.entries[0] = make_entry(OP_DESELECT, 8'h00);
            for (int k = 0; k < 8; k++) begin
              burst_o.entries[k+1] = open_seq[k];
            end
            addr_o           = open_addr;
            state_o.checking = spare_open;
            state_o.phase    = PH_WAIT;
          end else begin
            burst_o.entries[0] = make_entry(OP_DELIVER, item_i.flash_byte);
            burst_o.index      = state_i.delivered;
            state_o.delivered  = delivered_inc;
            addr_o             = addr_inc;
            if (delivered_inc == state_i.wanted) begin
              burst_o.count      = COUNT_W'(3);
              burst_o.entries[1] = make_entry(OP_DESELECT, 8'h00);
              burst_o.entries[2] = make_entry(OP_DONE, 8'h00);
              state_o.phase      = PH_IDLE;
            end else if (addr_inc[PageBits-1:0] == '0) begin
              // Page boundary crossed: close the page and open the next.
              burst_o.count      = COUNT_W'(10);
              burst_o.entries[1] = make_entry(OP_DESELECT, 8'h00);
              for (int k = 0; k < 8; k++) begin
                burst_o.entries[k+2] = open_seq[k];
              end
              state_o.checking = spare_open;
              state_o.phase    = PH_WAIT;
            end else begin
              burst_o.count      = COUNT_W'(2);
              burst_o.entries[1] = make_entry(OP_STROBE, 8'h00);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/nprs_burst.sv
// Burst buffer and output register of the NAND page read sequencer: holds
// the results of one request and hands them out one per cycle while out_ready_i is not held low. Uses nprs_pkg.
module nprs_burst (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_valid_i,
  input  nprs_pkg::burst_t burst_i,
  output logic             load_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output nprs_pkg::res_t   out_o
);
  import nprs_pkg::*;

  logic [COUNT_W-1:0]           count_q, count_d;
  res_entry_t [MAX_RESULTS-1:0] entries_q, entries_d;
  logic [INDEX_W-1:0]           index_q, index_d;
  logic                         out_valid_q, out_valid_d;
  res_t                         out_q;
  logic                         move;
  logic                         load;

  // A result moves into the output register when that register is free.
  assign move         = (count_q != '0) && (!out_valid_q || out_ready_i);
  assign load_ready_o = (count_q == '0) || (count_q == COUNT_W'(1) && move);
  assign load         = load_valid_i && load_ready_o && (burst_i.count != '0);

  // Shift the burst towards its head as results leave.
  always_comb begin
    count_d   = count_q;
    entries_d = entries_q;
    index_d   = index_q;
    if (load) begin
      count_d   = burst_i.count;
      entries_d = burst_i.entries;
      index_d   = burst_i.index;
    end else if (move) begin
      count_d   = COUNT_W'(count_q - COUNT_W'(1));
      entries_d = {res_entry_t'('0), entries_q[MAX_RESULTS-1:1]};
      index_d   = '0;
    end
  end

  assign out_valid_d = move || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
    index_q   <= index_d;
    if (move) begin
      out_q.operation    <= entries_q[0].op;
      out_q.bus_byte     <= entries_q[0].data;
      out_q.buffer_index <= index_q;
      out_q.last         <= (count_q == COUNT_W'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: src/nand_page_read_sequencer_top.sv
// Top level of the NAND page read sequencer: input register, sequencer
// state, next-state logic and burst buffer. Depends on nprs_pkg, nprs_if,
// nprs_step and nprs_burst.
//
//   channel   direction  transfer       payload
//   req_i     in         valid & ready  action, start_address, read_length,
//                                       ready_flag, flash_byte
//   res_o     out        valid & ready  operation, bus_byte, buffer_index, last
//
// A transfer is decoded from the input register once the burst buffer can take
// its 0 to 10 results; they leave one per cycle while res_o is not stalled.
// Reset clears the sequencer to idle with all counters at zero.
// A stalled result port holds the output register and the burst buffer; one
// further request then waits in the input register before req_i.ready falls.
module nand_page_read_sequencer_top #(
  parameter int unsigned PAGE_BYTES   = 2048,
  parameter int unsigned BLOCK_BYTES  = 131072,
  parameter int unsigned ADDRESS_BITS = 28
) (
  input logic         clk_i,
  input logic         rst_ni,
  nprs_req_if.sink    req_i,
  nprs_res_if.source  res_o
);
  import nprs_pkg::*;

  logic                    in_valid_q;
  item_t                   item_q;
  state_t                  state_q, state_d;
  logic [ADDRESS_BITS-1:0] addr_q, addr_d;
  burst_t                  burst;
  logic                    burst_ready;
  logic                    process;
  res_t                    res;

  // A held request is decoded once the burst buffer can take its results.
  assign process     = in_valid_q && burst_ready;
  assign req_i.ready = !in_valid_q || process;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      item_q.action        <= req_i.action;
      item_q.start_address <= req_i.start_address;
      item_q.read_length   <= req_i.read_length;
      item_q.ready_flag    <= req_i.ready_flag;
      item_q.flash_byte    <= req_i.flash_byte;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, delivered: '0, wanted: '0, checking: 1'b0};
      addr_q  <= '0;
    end else if (process) begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  nprs_step #(
    .PAGE_BYTES   (PAGE_BYTES),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_step (
    .item_i  (item_q),
    .state_i (state_q),
    .addr_i  (addr_q),
    .state_o (state_d),
    .addr_o  (addr_d),
    .burst_o (burst)
  );

  nprs_burst u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (process),
    .burst_i      (burst),
    .load_ready_o (burst_ready),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .out_o        (res)
  );

  assign res_o.operation    = res.operation;
  assign res_o.bus_byte     = res.bus_byte;
  assign res_o.buffer_index = res.buffer_index;
  assign res_o.last         = res.last;

endmodule

FILE: src/nprs_checker.sv
// Port checker for the NAND page read sequencer, bound to the top level.
// Depends on nprs_pkg and nand_page_read_sequencer_top.
module nprs_port_assert (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         res_valid_i,
  input logic         res_ready_i,
  input logic [2:0]   res_operation_i,
  input logic [7:0]   res_bus_byte_i,
  input logic [23:0]  res_buffer_index_i,
  input logic         res_last_i
);
  import nprs_pkg::*;

  // A stalled result stays offered.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result withdrawn while stalled");

  // Done always closes the burst of its request.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_operation_i == OP_DONE |-> res_last_i)
    else $error("done result without last");

  // Only a delivery carries a buffer index.
  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_operation_i != OP_DELIVER |-> res_buffer_index_i == '0)
    else $error("buffer index on a result that is not a delivery");

  // Operations without a byte show zero on the bus byte.
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_operation_i == OP_SELECT || res_operation_i == OP_DESELECT ||
                    res_operation_i == OP_STROBE || res_operation_i == OP_DONE)
    |-> res_bus_byte_i == 8'h00)
    else $error("bus byte set on an operation that carries none");

endmodule

bind nand_page_read_sequencer_top nprs_port_assert u_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .res_valid_i        (res_o.valid),
  .res_ready_i        (res_o.ready),
  .res_operation_i    (res_o.operation),
  .res_bus_byte_i     (res_o.bus_byte),
  .res_buffer_index_i (res_o.buffer_index),
  .res_last_i         (res_o.last)
);
